// ===== rtl/core/i2cbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbe_pkg: shared types and constants of the I2C master bit engine
// Command codes, classified queue items, engine state and the beat structs.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

  // command codes on the input beat
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [2:0] PH_END         = 3'd7;
  localparam logic [7:0] READ_TAIL_HOLD = 8'd3;
  localparam logic [3:0] BITS_PER_BYTE  = 4'd8;
  localparam int         QDEPTH         = 2;

  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_START,
    KIND_STOP,
    KIND_WRITE,
    KIND_READ,
    KIND_NOP
  } kind_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_START,
    OP_STOP,
    OP_WRITE,
    OP_READ
  } op_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       send_nack;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_bit;
  } out_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] tx_byte;
    logic       send_nack;
    logic       sda_in;
  } item_t;

endpackage

// ===== rtl/core/i2cbe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbe_front: input classifier
// Decode the command code of each input beat into a queue item.
// ----------------------------------------------------------------------------
module i2cbe_front import i2cbe_pkg::*; (
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  in_t   in_data_i,
  output logic  push_o,
  output item_t item_o,
  input  logic  full_i
);

  assign in_ready_o = ~full_i;
  assign push_o     = in_valid_i & ~full_i;

  always_comb begin
    item_o.tx_byte   = in_data_i.tx_byte;
    item_o.send_nack = in_data_i.send_nack;
    item_o.sda_in    = in_data_i.sda_in;
    unique case (in_data_i.command)
      CMD_TICK:  item_o.kind = KIND_TICK;
      CMD_START: item_o.kind = KIND_START;
      CMD_STOP:  item_o.kind = KIND_STOP;
      CMD_WRITE: item_o.kind = KIND_WRITE;
      CMD_READ:  item_o.kind = KIND_READ;
      default:   item_o.kind = KIND_NOP;
    endcase
  end

endmodule

// ===== rtl/core/i2cbe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbe_queue: item queue
// Small register FIFO between the classifier and the engine.
// ----------------------------------------------------------------------------
module i2cbe_queue import i2cbe_pkg::*; #(
  parameter int Depth = QDEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/core/i2cbe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbe_back: bus phase engine
// Step the SCL/SDA phase sequence one item at a time and register results.
// ----------------------------------------------------------------------------
module i2cbe_back import i2cbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       valid_i,
  input  item_t      item_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o
);

  op_e        op_q, op_d;
  logic [2:0] ph_q, ph_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] hold_q, hold_d;
  logic [7:0] shift_q, shift_d;
  logic       nack_q, nack_d;
  logic       scl_q, scl_d, drv_q, drv_d, sda_q, sda_d;
  logic       ack_q, ack_d;
  logic [7:0] rx_q, rx_d;
  logic [7:0] ticks_q;
  logic       done;
  logic       ovalid_q;
  out_t       out_q;
  logic [2:0] nxt;
  logic [7:0] hold;
  logic [3:0] bit_inc;

  assign pop_o       = valid_i & (~ovalid_q | out_ready_i);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;
  assign bit_inc     = bit_q + 1'b1;

  always_comb begin
    op_d    = op_q;
    ph_d    = ph_q;
    bit_d   = bit_q;
    hold_d  = hold_q;
    shift_d = shift_q;
    nack_d  = nack_q;
    scl_d   = scl_q;
    drv_d   = drv_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    rx_d    = rx_q;
    done    = 1'b0;
    nxt     = ph_q + 1'b1;
    hold    = ticks_q;
    unique case (op_q)
      OP_IDLE: begin
        ph_d   = '0;
        bit_d  = '0;
        hold_d = '0;
        case (item_i.kind)
          KIND_START: op_d = OP_START;
          KIND_STOP:  op_d = OP_STOP;
          KIND_WRITE: begin
            op_d    = OP_WRITE;
            shift_d = item_i.tx_byte;
          end
          KIND_READ: begin
            op_d    = OP_READ;
            shift_d = '0;
            nack_d  = item_i.send_nack;
          end
          default: begin
            ph_d   = ph_q;
            bit_d  = bit_q;
            hold_d = hold_q;
          end
        endcase
      end
      default: begin
        if (item_i.kind == KIND_TICK) begin
          if (hold_q != '0) begin
            hold_d = hold_q - 1'b1;
            if (hold_d == '0 && ph_q == PH_END) begin
              done = 1'b1;
            end
          end else begin
            // run the current phase
            unique case (op_q)
              OP_START: begin
                if (ph_q == 3'd0) begin
                  drv_d = 1'b1;
                  sda_d = 1'b1;
                end else if (ph_q == 3'd1) begin
                  scl_d = 1'b1;
                  sda_d = 1'b0;
                end else begin
                  scl_d = 1'b0;
                  hold  = '0;
                  nxt   = PH_END;
                end
              end
              OP_STOP: begin
                if (ph_q == 3'd0) begin
                  scl_d = 1'b1;
                end else begin
                  sda_d = 1'b1;
                  nxt   = PH_END;
                end
              end
              OP_WRITE: begin
                if (ph_q == 3'd0) begin
                  sda_d = shift_q[7];
                end else if (ph_q == 3'd1) begin
                  scl_d   = 1'b1;
                  shift_d = {shift_q[6:0], 1'b0};
                  bit_d   = bit_inc;
                end else if (ph_q == 3'd2) begin
                  scl_d = 1'b0;
                  nxt   = (bit_q < BITS_PER_BYTE) ? 3'd0 : 3'd3;
                end else if (ph_q == 3'd3) begin
                  drv_d = 1'b0;
                end else if (ph_q == 3'd4) begin
                  scl_d = 1'b1;
                end else begin
                  ack_d = item_i.sda_in;
                  scl_d = 1'b0;
                  sda_d = 1'b0;
                  drv_d = 1'b1;
                  hold  = '0;
                  nxt   = PH_END;
                end
              end
              default: begin
                if (ph_q == 3'd0) begin
                  drv_d   = 1'b0;
                  shift_d = {shift_q[6:0], 1'b0};
                  scl_d   = 1'b1;
                end else if (ph_q == 3'd1) begin
                  shift_d = {shift_q[7:1], shift_q[0] | item_i.sda_in};
                  scl_d   = 1'b0;
                  bit_d   = bit_inc;
                  nxt     = (bit_inc < BITS_PER_BYTE) ? 3'd0 : 3'd2;
                end else if (ph_q == 3'd2) begin
                  drv_d = 1'b1;
                  sda_d = nack_q;
                end else if (ph_q == 3'd3) begin
                  scl_d = 1'b1;
                end else begin
                  scl_d = 1'b0;
                  sda_d = 1'b0;
                  hold  = READ_TAIL_HOLD;
                  nxt   = PH_END;
                end
              end
            endcase
            ph_d   = nxt;
            hold_d = hold;
            done   = (nxt == PH_END) && (hold == '0);
          end
          if (done) begin
            if (op_q == OP_READ) begin
              rx_d = shift_d;
            end
            op_d   = OP_IDLE;
            ph_d   = '0;
            hold_d = '0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= OP_IDLE;
      ph_q     <= '0;
      bit_q    <= '0;
      hold_q   <= '0;
      shift_q  <= '0;
      nack_q   <= 1'b0;
      scl_q    <= 1'b1;
      drv_q    <= 1'b1;
      sda_q    <= 1'b1;
      ack_q    <= 1'b0;
      rx_q     <= '0;
      ticks_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ticks_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        op_q    <= op_d;
        ph_q    <= ph_d;
        bit_q   <= bit_d;
        hold_q  <= hold_d;
        shift_q <= shift_d;
        nack_q  <= nack_d;
        scl_q   <= scl_d;
        drv_q   <= drv_d;
        sda_q   <= sda_d;
        ack_q   <= ack_d;
        rx_q    <= rx_d;
      end
      if (pop_o) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.scl_level <= scl_d;
      out_q.sda_drive <= drv_d;
      out_q.sda_level <= sda_d;
      out_q.busy_res  <= (op_d != OP_IDLE);
      out_q.done_res  <= done;
      out_q.rx_byte   <= rx_d;
      out_q.ack_bit   <= ack_d;
    end
  end

endmodule

// ===== rtl/core/i2c_master_bit_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit: I2C master bit engine
// Byte level commands stepped through SCL/SDA bus phases by tick beats.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   in      | input     | in_valid_i/in_ready_o | in_data_i  (in_t)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (out_t)
//   cfg     | input     | cfg_we_i              | cfg_wdata_i (phase_ticks)
//
// Every input beat yields exactly one output beat. Throughput is one beat per
// cycle while the output is not stalled; an accepted beat is written into the
// queue, and the engine update is then registered into the output register.
// The engine state update is the step that sets that rate.
// Reset is asynchronous and active low: pins come up SCL high, SDA driven
// high, engine idle, phase_ticks zero.
// A stalled output holds its beat; the queue keeps taking input until full.
//
module i2c_master_bit_engine_unit import i2cbe_pkg::*; #(
  parameter int QueueDepth = QDEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o
);

  // classifier to queue
  logic  push;
  logic  full;
  item_t push_item;

  // queue to engine
  logic  pop;
  logic  q_valid;
  item_t q_item;

  // decode each beat's command; stall input when the queue is full
  i2cbe_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .item_o     (push_item),
    .full_i     (full)
  );

  // decouple the classifier from the engine so each side stalls on its own
  i2cbe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // advance the bus phase engine and hold the result in the output register
  i2cbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/i2cbe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbe_checker: port level checks of the I2C master bit engine
// Watch the output beats for engine consistency and a held stall.
// ----------------------------------------------------------------------------
module i2cbe_checker import i2cbe_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input out_t out_data_i
);

  // a completing beat always leaves the engine idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.done_res |-> !out_data_i.busy_res)
    else $error("done reported while still busy");

  // SDA is released only in the middle of a command
  a_release_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.sda_drive |-> out_data_i.busy_res)
    else $error("SDA released while idle");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output beat changed under stall");

endmodule

bind i2c_master_bit_engine_unit i2cbe_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the I2C master bit engine
// Drives command and tick beats through the valid/ready input. Every output
// beat is checked field by field against a cycle-free model of the bus phase
// sequencer or the directed table. The run covers hold counts 0, 255 and small
// values, random stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import i2cbe_pkg::*;

  // codes 5 to 7 decode to nothing in the engine
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam int RAND_BEATS_PER_PHASE = 12;
  localparam int HOLD_OFF_CYCLES      = 300;
  localparam int SETTLE_CYCLES        = 8;

  // SDA pattern that a transfer sees on its tick beats
  typedef enum logic [1:0] {
    SDA_ALL_LOW,
    SDA_ALL_HIGH,
    SDA_RANDOM
  } sda_pat_e;

  // one row of the directed table; want is only used where check_typed is set
  typedef struct packed {
    in_t  beat;
    logic check_typed;
    out_t want;
  } plan_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_t        in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_t       out_data_o;

  // bus model state
  op_e        eng_op;
  logic [2:0] eng_phase;
  logic [3:0] eng_bits;
  logic [7:0] eng_hold;
  logic [7:0] eng_shift;
  logic       eng_nack;
  logic       pin_scl;
  logic       pin_drv;
  logic       pin_sda;
  logic       eng_ack;
  logic [7:0] last_rx;
  logic [7:0] hold_cfg;

  out_t      pending_q[$];
  plan_row_t plan_q[$];
  int        fail_count = 0;
  int        beats_sent = 0;
  bit        calm       = 1'b0;   // suppress random idling on both sides
  bit        hold_off   = 1'b0;   // ask the receiver for one long stall

  i2c_master_bit_engine_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or drops a beat.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Bus phase model
  // --------------------------------------------------------------------------

  // Clear the engine back to idle; a read latches its byte on the way out.
  function automatic logic finish_cmd();
    if (eng_op == OP_READ) last_rx = eng_shift;
    eng_op    = OP_IDLE;
    eng_phase = 3'd0;
    eng_hold  = 8'd0;
    return 1'b1;
  endfunction

  // Run the phase at eng_phase once its hold has expired.
  function automatic logic run_phase(input logic sda);
    logic [2:0] p;
    logic [2:0] nxt;
    logic [7:0] hold;
    p    = eng_phase;
    hold = hold_cfg;
    nxt  = p + 3'd1;
    case (eng_op)
      OP_START: begin
        if (p == 3'd0) begin
          pin_drv = 1'b1;
          pin_sda = 1'b1;
        end else if (p == 3'd1) begin
          pin_scl = 1'b1;
          pin_sda = 1'b0;
        end else begin
          // SCL low ends the start condition with no trailing hold
          pin_scl = 1'b0;
          hold    = 8'd0;
          nxt     = PH_END;
        end
      end
      OP_STOP: begin
        if (p == 3'd0) begin
          pin_scl = 1'b1;
        end else begin
          pin_sda = 1'b1;
          nxt     = PH_END;
        end
      end
      OP_WRITE: begin
        case (p)
          3'd0: pin_sda = eng_shift[7];   // level only, drive enable untouched
          3'd1: begin
            pin_scl   = 1'b1;
            eng_shift = eng_shift << 1;
            eng_bits  = eng_bits + 4'd1;
          end
          3'd2: begin
            pin_scl = 1'b0;
            nxt     = (eng_bits < BITS_PER_BYTE) ? 3'd0 : 3'd3;
          end
          3'd3: pin_drv = 1'b0;
          3'd4: pin_scl = 1'b1;
          default: begin
            // acknowledge slot: sample, then take SDA back low and driven
            eng_ack = sda;
            pin_scl = 1'b0;
            pin_sda = 1'b0;
            pin_drv = 1'b1;
            hold    = 8'd0;
            nxt     = PH_END;
          end
        endcase
      end
      default: begin
        case (p)
          3'd0: begin
            pin_drv   = 1'b0;
            eng_shift = eng_shift << 1;
            pin_scl   = 1'b1;
          end
          3'd1: begin
            if (sda) eng_shift[0] = 1'b1;
            pin_scl  = 1'b0;
            eng_bits = eng_bits + 4'd1;
            nxt      = (eng_bits < BITS_PER_BYTE) ? 3'd0 : 3'd2;
          end
          3'd2: begin
            pin_drv = 1'b1;
            pin_sda = eng_nack;
          end
          3'd3: pin_scl = 1'b1;
          default: begin
            pin_scl = 1'b0;
            pin_sda = 1'b0;
            hold    = READ_TAIL_HOLD;
            nxt     = PH_END;
          end
        endcase
      end
    endcase
    eng_phase = nxt;
    eng_hold  = hold;
    if (nxt == PH_END && hold == 8'd0) return finish_cmd();
    return 1'b0;
  endfunction

  // Advance the model by one accepted input beat and return the output beat.
  function automatic out_t bus_step(input in_t b);
    out_t r;
    logic done;
    done = 1'b0;
    if (eng_op == OP_IDLE) begin
      // only a valid command leaves idle; ticks and codes 5..7 do nothing
      case (b.command)
        CMD_START: eng_op = OP_START;
        CMD_STOP:  eng_op = OP_STOP;
        CMD_WRITE: eng_op = OP_WRITE;
        CMD_READ:  eng_op = OP_READ;
        default:   eng_op = OP_IDLE;
      endcase
      if (eng_op != OP_IDLE) begin
        eng_phase = 3'd0;
        eng_bits  = 4'd0;
        eng_hold  = 8'd0;
        if (eng_op == OP_WRITE) eng_shift = b.tx_byte;
        if (eng_op == OP_READ) begin
          eng_shift = 8'h00;
          eng_nack  = b.send_nack;
        end
      end
    end else if (b.command == CMD_TICK) begin
      if (eng_hold != 8'd0) begin
        eng_hold = eng_hold - 8'd1;
        if (eng_hold == 8'd0 && eng_phase == PH_END) done = finish_cmd();
      end else begin
        done = run_phase(b.sda_in);
      end
    end
    r.scl_level = pin_scl;
    r.sda_drive = pin_drv;
    r.sda_level = pin_sda;
    r.busy_res  = (eng_op != OP_IDLE);
    r.done_res  = done;
    r.rx_byte   = last_rx;
    r.ack_bit   = eng_ack;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 24);
  endfunction

  // Offer one beat, hold it until accepted, then log its expected result.
  task automatic send_beat(input in_t b, input logic typed = 1'b0,
                           input out_t typed_want = '0);
    out_t predicted;
    if (take_break()) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (take_break());
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = bus_step(b);
    pending_q.push_back(typed ? typed_want : predicted);
    beats_sent++;
  endtask

  // Drop valid and wait for the last expected beat plus a little slack.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_phase_ticks(input logic [7:0] v);
    drain();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    hold_cfg    = v;
  endtask

  // Issue cmd if the engine is idle, then tick until it is idle again.
  // Commands thrown in while busy must be ignored by the engine.
  task automatic run_transfer(input logic [2:0] cmd, input logic [7:0] tx,
                              input logic nack, input sda_pat_e pat);
    in_t b;
    if (eng_op == OP_IDLE) begin
      b.command   = cmd;
      b.tx_byte   = tx;
      b.send_nack = nack;
      b.sda_in    = 1'($urandom_range(0, 1));
      send_beat(b);
    end
    while (eng_op != OP_IDLE) begin
      b.tx_byte   = 8'($urandom_range(0, 255));
      b.send_nack = 1'($urandom_range(0, 1));
      if (pat == SDA_RANDOM && $urandom_range(0, 9) == 0) begin
        b.command = 3'($urandom_range(1, 7));
        b.sda_in  = 1'($urandom_range(0, 1));
      end else begin
        b.command = CMD_TICK;
        case (pat)
          SDA_ALL_LOW:  b.sda_in = 1'b0;
          SDA_ALL_HIGH: b.sda_in = 1'b1;
          default:      b.sda_in = 1'($urandom_range(0, 1));
        endcase
      end
      send_beat(b);
    end
  endtask

  function automatic logic [2:0] pick_command();
    case ($urandom_range(0, 9))
      0, 1:    return CMD_START;
      2, 3:    return CMD_STOP;
      4, 5, 6: return CMD_WRITE;
      default: return CMD_READ;
    endcase
  endfunction

  task automatic add_row(input logic [2:0] cmd, input logic [7:0] tx,
                         input logic nack, input logic sda, input out_t want);
    plan_row_t row;
    row.beat.command   = cmd;
    row.beat.tx_byte   = tx;
    row.beat.send_nack = nack;
    row.beat.sda_in    = sda;
    row.check_typed    = 1'b1;
    row.want           = want;
    plan_q.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off = 1'b0;
      end else begin
        out_ready_i <= !take_break();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each output beat with the oldest expectation
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected output beat, expected none, actual %h",
                 $time, out_data_o);
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        check_field("scl_level", 8'(want.scl_level), 8'(out_data_o.scl_level));
        check_field("sda_drive", 8'(want.sda_drive), 8'(out_data_o.sda_drive));
        check_field("sda_level", 8'(want.sda_level), 8'(out_data_o.sda_level));
        check_field("busy_res",  8'(want.busy_res),  8'(out_data_o.busy_res));
        check_field("done_res",  8'(want.done_res),  8'(out_data_o.done_res));
        check_field("rx_byte",   want.rx_byte,       out_data_o.rx_byte);
        check_field("ack_bit",   8'(want.ack_bit),   8'(out_data_o.ack_bit));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int start_count;
    logic [7:0] phase_vals[4];

    // model reset: SCL high, SDA driven high, idle
    eng_op    = OP_IDLE;
    eng_phase = 3'd0;
    eng_bits  = 4'd0;
    eng_hold  = 8'd0;
    eng_shift = 8'h00;
    eng_nack  = 1'b0;
    pin_scl   = 1'b1;
    pin_drv   = 1'b1;
    pin_sda   = 1'b1;
    eng_ack   = 1'b0;
    last_rx   = 8'h00;
    hold_cfg  = 8'h00;

    // Directed table, phase_ticks 0. Expected beats are packed as
    // {scl, drive, sda, busy, done, rx_byte, ack}.
    add_row(CMD_TICK,  8'h00, 1'b0, 1'b0, {3'b111, 1'b0, 1'b0, 8'h00, 1'b0}); // idle tick
    add_row(CMD_RSVD5, 8'hFF, 1'b1, 1'b1, {3'b111, 1'b0, 1'b0, 8'h00, 1'b0}); // dead codes
    add_row(CMD_RSVD7, 8'hFF, 1'b1, 1'b1, {3'b111, 1'b0, 1'b0, 8'h00, 1'b0});
    add_row(CMD_START, 8'h00, 1'b0, 1'b0, {3'b111, 1'b1, 1'b0, 8'h00, 1'b0}); // load only
    add_row(CMD_STOP,  8'hFF, 1'b1, 1'b1, {3'b111, 1'b1, 1'b0, 8'h00, 1'b0}); // busy: ignore
    add_row(CMD_READ,  8'hFF, 1'b1, 1'b1, {3'b111, 1'b1, 1'b0, 8'h00, 1'b0});
    add_row(CMD_TICK,  8'h00, 1'b0, 1'b1, {3'b111, 1'b1, 1'b0, 8'h00, 1'b0});
    add_row(CMD_TICK,  8'h00, 1'b0, 1'b0, {3'b110, 1'b1, 1'b0, 8'h00, 1'b0}); // SDA falls
    add_row(CMD_TICK,  8'h00, 1'b0, 1'b0, {3'b010, 1'b0, 1'b1, 8'h00, 1'b0}); // start done
    add_row(CMD_TICK,  8'hFF, 1'b1, 1'b1, {3'b010, 1'b0, 1'b0, 8'h00, 1'b0});
    add_row(CMD_STOP,  8'h00, 1'b0, 1'b0, {3'b010, 1'b1, 1'b0, 8'h00, 1'b0});
    add_row(CMD_TICK,  8'h00, 1'b0, 1'b0, {3'b110, 1'b1, 1'b0, 8'h00, 1'b0});
    add_row(CMD_TICK,  8'h00, 1'b0, 1'b0, {3'b111, 1'b0, 1'b1, 8'h00, 1'b0}); // stop done
    add_row(CMD_WRITE, 8'hFF, 1'b0, 1'b0, {3'b111, 1'b1, 1'b0, 8'h00, 1'b0});
    add_row(CMD_WRITE, 8'h00, 1'b1, 1'b0, {3'b111, 1'b1, 1'b0, 8'h00, 1'b0}); // busy: ignore
    add_row(CMD_TICK,  8'h00, 1'b0, 1'b0, {3'b111, 1'b1, 1'b0, 8'h00, 1'b0}); // MSB is 1
    add_row(CMD_TICK,  8'h00, 1'b0, 1'b0, {3'b111, 1'b1, 1'b0, 8'h00, 1'b0});
    add_row(CMD_TICK,  8'h00, 1'b0, 1'b0, {3'b011, 1'b1, 1'b0, 8'h00, 1'b0});
    add_row(CMD_RSVD6, 8'h5A, 1'b1, 1'b1, {3'b011, 1'b1, 1'b0, 8'h00, 1'b0});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_phase_ticks(8'd0);
    foreach (plan_q[i]) begin
      send_beat(plan_q[i].beat, plan_q[i].check_typed, plan_q[i].want);
    end
    // finish the write left open by the table, checked by the model only
    run_transfer(CMD_TICK, 8'h00, 1'b0, SDA_RANDOM);

    // Longest hold count: one stop, with the output held off long enough
    // for the queue to fill and back up the input.
    set_phase_ticks(8'd255);
    hold_off = 1'b1;
    run_transfer(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);

    phase_vals[0] = 8'd1;
    phase_vals[1] = 8'd0;
    phase_vals[2] = 8'd2;
    phase_vals[3] = 8'($urandom_range(0, 3));
    for (int ph = 0; ph < 4; ph++) begin
      // each phase change also makes the sender wait out every result
      set_phase_ticks(phase_vals[ph]);
      calm = (ph == 2);
      if (ph == 0) begin
        // byte and line extremes first
        run_transfer(CMD_WRITE, 8'h00, 1'b0, SDA_ALL_LOW);
        run_transfer(CMD_READ,  8'h00, 1'b1, SDA_ALL_HIGH);
        run_transfer(CMD_READ,  8'hFF, 1'b0, SDA_ALL_LOW);
        run_transfer(CMD_WRITE, 8'hFF, 1'b1, SDA_ALL_HIGH);
      end
      start_count = beats_sent;
      while (beats_sent - start_count < RAND_BEATS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 80) begin
          run_transfer(pick_command(), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), SDA_RANDOM);
        end else begin
          // noise: any code, any time; a command that lands while idle
          // simply starts a transfer that the next pass ticks through
          send_beat(in_t'(13'($urandom)));
        end
      end
      calm = 1'b0;
    end

    drain();
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
